// ===== src/tex_math_delimiter_tagger_top_defines.svh =====
// Assertion macros for the math delimiter tagger.
// TMDT_ASSERT is disabled while rst is high; TMDT_ASSERT_RST also checks during reset.
`ifndef TEX_MATH_DELIMITER_TAGGER_TOP_DEFINES_SVH
`define TEX_MATH_DELIMITER_TAGGER_TOP_DEFINES_SVH

`ifndef ASSERT_OFF
`define TMDT_ASSERT(name, clk, rst, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define TMDT_ASSERT_RST(name, clk, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TMDT_ASSERT(name, clk, rst, prop, msg)
`define TMDT_ASSERT_RST(name, clk, prop, msg)
`endif

`endif

// ===== src/tmdt_pkg.sv =====
`default_nettype none
package tmdt_pkg;

  localparam int QUEUE_DEPTH = 4;

  localparam logic [7:0] CH_ESCAPE = 8'h5C;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_M      = 8'h6D;
  localparam logic [7:0] CH_A      = 8'h61;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_H      = 8'h68;

  localparam logic [2:0] OPEN_TAG_LEN  = 3'd6;
  localparam logic [2:0] CLOSE_TAG_LEN = 3'd7;

  typedef enum logic [1:0] {
    MODE_TEXT,
    MODE_OPENING,
    MODE_MATH,
    MODE_CLOSING
  } mode_t;

  typedef enum logic [1:0] {
    TAG_NONE,
    TAG_OPEN,
    TAG_CLOSE
  } tag_kind_t;

  // one unit of work for the emitter: optional tag, then optional byte
  typedef struct packed {
    tag_kind_t  tag;
    logic       has_byte;
    logic [7:0] data;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  function automatic logic [2:0] tag_len(input tag_kind_t k);
    logic [2:0] n;
    case (k)
      TAG_OPEN:  n = OPEN_TAG_LEN;
      TAG_CLOSE: n = CLOSE_TAG_LEN;
      default:   n = 3'd0;
    endcase
    return n;
  endfunction

  function automatic logic [7:0] tag_char(input tag_kind_t k, input logic [2:0] i);
    logic [7:0] c;
    c = CH_GT;
    if (k == TAG_CLOSE) begin
      case (i)
        3'd0:    c = CH_LT;
        3'd1:    c = CH_SLASH;
        3'd2:    c = CH_M;
        3'd3:    c = CH_A;
        3'd4:    c = CH_T;
        3'd5:    c = CH_H;
        default: c = CH_GT;
      endcase
    end else begin
      case (i)
        3'd0:    c = CH_LT;
        3'd1:    c = CH_M;
        3'd2:    c = CH_A;
        3'd3:    c = CH_T;
        3'd4:    c = CH_H;
        default: c = CH_GT;
      endcase
    end
    return c;
  endfunction

endpackage
`default_nettype wire

// ===== src/tmdt_ifs.sv =====
`default_nettype none
interface tmdt_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_stream;
  modport source (output valid, in_byte, end_of_stream, input ready);
  modport sink   (input valid, in_byte, end_of_stream, output ready);
endinterface

interface tmdt_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_of_run;
  modport source (output valid, out_byte, last_of_run, input ready);
  modport sink   (input valid, out_byte, last_of_run, output ready);
endinterface
`default_nettype wire

// ===== src/tmdt_queue.sv =====
`default_nettype none
`include "tex_math_delimiter_tagger_top_defines.svh"
module tmdt_queue #(
  parameter int DEPTH = tmdt_pkg::QUEUE_DEPTH
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  input  wire tmdt_pkg::job_t  push_data,
  input  wire logic            pop,
  output tmdt_pkg::job_t       pop_data,
  output tmdt_pkg::q_stat_t    stat
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

  tmdt_pkg::job_t  slots [DEPTH];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;
  logic            do_push;
  logic            do_pop;

  assign stat.full  = (count == FullCnt);
  assign stat.empty = (count == '0);
  assign pop_data   = slots[rd_ptr];
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LastPtr) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LastPtr) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  `TMDT_ASSERT(a_no_push_full, clk, rst, stat.full |-> !push, "push into full queue")
  `TMDT_ASSERT(a_count_bound, clk, rst, count <= FullCnt, "queue count overflow")
  `TMDT_ASSERT_RST(a_empty_after_rst, clk, $past(rst) |-> stat.empty, "queue not empty after reset")

endmodule
`default_nettype wire

// ===== src/tmdt_front.sv =====
`default_nettype none
`include "tex_math_delimiter_tagger_top_defines.svh"
module tmdt_front (
  input  wire logic          clk,
  input  wire logic          rst,
  tmdt_in_if.sink            din,
  input  wire logic          q_full,
  output logic               push,
  output tmdt_pkg::job_t     push_job
);

  tmdt_pkg::mode_t mode;
  tmdt_pkg::mode_t mode_next;
  logic            esc;
  logic            esc_next;
  logic            fire;
  logic            is_dollar;
  logic            is_esc;
  logic            eos;

  assign din.ready = !q_full;
  assign fire      = din.valid && din.ready;
  assign is_dollar = (din.in_byte == tmdt_pkg::CH_DOLLAR);
  assign is_esc    = (din.in_byte == tmdt_pkg::CH_ESCAPE);
  assign eos       = din.end_of_stream;

  // next state
  always_comb begin
    mode_next = mode;
    esc_next  = esc;
    if (fire) begin
      if (esc) begin
        esc_next = 1'b0;
      end else begin
        case (mode)
          tmdt_pkg::MODE_TEXT: begin
            if (is_dollar) mode_next = tmdt_pkg::MODE_OPENING;
            esc_next = is_esc;
          end
          tmdt_pkg::MODE_OPENING: begin
            mode_next = tmdt_pkg::MODE_MATH;
            esc_next  = is_esc;
          end
          tmdt_pkg::MODE_MATH: begin
            if (is_dollar) mode_next = tmdt_pkg::MODE_CLOSING;
            esc_next = is_esc;
          end
          tmdt_pkg::MODE_CLOSING: begin
            mode_next = tmdt_pkg::MODE_TEXT;
            esc_next  = is_esc;
          end
          default: begin
            mode_next = tmdt_pkg::MODE_TEXT;
          end
        endcase
      end
      if (eos) begin
        mode_next = tmdt_pkg::MODE_TEXT;
        esc_next  = 1'b0;
      end
    end
  end

  // job for the emitter; a delimiter dollar makes no job
  always_comb begin
    push_job.tag      = tmdt_pkg::TAG_NONE;
    push_job.has_byte = !is_dollar;
    push_job.data     = din.in_byte;
    if (esc) begin
      push_job.has_byte = 1'b1;
    end else begin
      case (mode)
        tmdt_pkg::MODE_OPENING: push_job.tag = tmdt_pkg::TAG_OPEN;
        tmdt_pkg::MODE_CLOSING: push_job.tag = tmdt_pkg::TAG_CLOSE;
        default:                push_job.tag = tmdt_pkg::TAG_NONE;
      endcase
    end
    push = fire && (push_job.has_byte || push_job.tag != tmdt_pkg::TAG_NONE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= tmdt_pkg::MODE_TEXT;
      esc  <= 1'b0;
    end else begin
      mode <= mode_next;
      esc  <= esc_next;
    end
  end

  `TMDT_ASSERT(a_eos_clears, clk, rst, fire && eos |=> mode == tmdt_pkg::MODE_TEXT && !esc, "state kept past end of stream")
  `TMDT_ASSERT(a_esc_source, clk, rst, $rose(esc) |-> $past(fire && is_esc), "escape set without backslash")
  `TMDT_ASSERT(a_esc_holds_mode, clk, rst, fire && esc && !eos |=> mode == $past(mode), "escaped byte changed mode")

endmodule
`default_nettype wire

// ===== src/tmdt_back.sv =====
`default_nettype none
module tmdt_back (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          q_empty,
  input  wire tmdt_pkg::job_t q_data,
  output logic               pop,
  tmdt_out_if.source         dout
);

  logic           cur_valid;
  tmdt_pkg::job_t cur;
  logic [2:0]     idx;
  logic           out_valid;
  logic [7:0]     out_byte_r;
  logic           out_last_r;

  logic [2:0]     tlen;
  logic           in_tag;
  logic [7:0]     ch;
  logic           last;
  logic           load;
  logic           take;

  assign tlen   = tmdt_pkg::tag_len(cur.tag);
  assign in_tag = (idx < tlen);
  assign ch     = in_tag ? tmdt_pkg::tag_char(cur.tag, idx) : cur.data;
  assign last   = in_tag ? ((idx == tlen - 3'd1) && !cur.has_byte) : 1'b1;
  assign load   = cur_valid && (!out_valid || dout.ready);
  // job slot is free at this edge: empty, or its final byte goes out now
  assign take   = !cur_valid || (load && last);
  assign pop    = take && !q_empty;

  assign dout.valid       = out_valid;
  assign dout.out_byte    = out_byte_r;
  assign dout.last_of_run = out_last_r;

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      out_valid <= 1'b0;
      idx       <= '0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
      end else if (dout.ready) begin
        out_valid <= 1'b0;
      end
      if (take) begin
        cur_valid <= !q_empty;
        idx       <= '0;
      end else if (load) begin
        idx <= idx + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      cur <= q_data;
    end
    if (load) begin
      out_byte_r <= ch;
      out_last_r <= last;
    end
  end

endmodule
`default_nettype wire

// ===== src/tex_math_delimiter_tagger_top.sv =====
// A plain byte reaches dout via the job queue, the job register cur and the output register.
// Throughput: one request per cycle while each maps to one output byte and dout is
//   ready; the request after a delimiter dollar holds the single output port while
//   its tag of 6 or 7 characters goes out, absorbed by the job queue.
// Reset (rst, synchronous): text mode, escape cleared, queue emptied, dout idle.
`default_nettype none
module tex_math_delimiter_tagger_top #(
  parameter int QUEUE_DEPTH = tmdt_pkg::QUEUE_DEPTH
) (
  input  wire logic  clk,
  input  wire logic  rst,
  tmdt_in_if.sink    din,
  tmdt_out_if.source dout
);

  // front: tracks text/math mode and escape flag, turns each request into a job
  // (pending tag plus optional byte). Jobs with nothing to emit are dropped here.
  // back: expands a job into tag characters then the byte, tags last_of_run.
  tmdt_pkg::job_t    push_job;
  tmdt_pkg::job_t    pop_job;
  tmdt_pkg::q_stat_t q_stat;
  logic              push;
  logic              pop;

  tmdt_front u_front (
    .clk      (clk),
    .rst      (rst),
    .din      (din),
    .q_full   (q_stat.full),
    .push     (push),
    .push_job (push_job)
  );

  // decouples classification from emission so tag bursts do not stall intake at once
  tmdt_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_job),
    .pop       (pop),
    .pop_data  (pop_job),
    .stat      (q_stat)
  );

  tmdt_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_empty (q_stat.empty),
    .q_data  (pop_job),
    .pop     (pop),
    .dout    (dout)
  );

endmodule
`default_nettype wire

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;

  // One output character as seen on dout: the byte and the end-of-run mark.
  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } tag_char_t;

  // Directed row: the request, and where the outcome is obvious, the output text
  // typed in (fixed = 0 leaves the row to the predictor).
  typedef struct {
    logic [7:0] in_byte;
    logic       eos;
    bit         fixed;
    string      text;
  } dir_row_t;

  localparam int N_DIR       = 26;
  localparam int N_RANDOM    = 280;
  localparam int CYCLE_LIMIT = 400000;
  localparam int LONG_HOLD   = 300;
  localparam int END_WAIT    = 20;

  logic clk;
  logic rst;

  tmdt_in_if  din ();
  tmdt_out_if dout ();

  tex_math_delimiter_tagger_top dut (
    .clk  (clk),
    .rst  (rst),
    .din  (din),
    .dout (dout)
  );

  // Walk-through of the mode machine. Mode comments give the state before the row.
  dir_row_t dir_tab [N_DIR] = '{
    '{"A",                 1'b0, 1'b1, "A"},           // text, plain byte
    '{8'h00,               1'b0, 1'b0, ""},            // lowest byte
    '{8'hFF,               1'b0, 1'b0, ""},            // highest byte
    '{tmdt_pkg::CH_DOLLAR, 1'b0, 1'b1, ""},            // opening dollar, nothing out yet
    '{"x",                 1'b0, 1'b1, "<math>x"},     // lazy open tag
    '{tmdt_pkg::CH_ESCAPE, 1'b0, 1'b1, "\\"},          // escape in math
    '{tmdt_pkg::CH_DOLLAR, 1'b0, 1'b1, "$"},           // escaped dollar copied alone
    '{tmdt_pkg::CH_DOLLAR, 1'b0, 1'b1, ""},            // closing dollar
    '{tmdt_pkg::CH_DOLLAR, 1'b0, 1'b1, "</math>"},     // second dollar swallowed
    '{tmdt_pkg::CH_DOLLAR, 1'b0, 1'b1, ""},
    '{tmdt_pkg::CH_DOLLAR, 1'b0, 1'b1, "<math>"},      // $$ opening
    '{tmdt_pkg::CH_ESCAPE, 1'b0, 1'b1, "\\"},
    '{tmdt_pkg::CH_ESCAPE, 1'b0, 1'b1, "\\"},          // escaped backslash
    '{tmdt_pkg::CH_DOLLAR, 1'b0, 1'b1, ""},
    '{tmdt_pkg::CH_ESCAPE, 1'b0, 1'b1, "</math>\\"},   // backslash while closing
    '{"q",                 1'b0, 1'b1, "q"},
    '{tmdt_pkg::CH_DOLLAR, 1'b0, 1'b1, ""},
    '{tmdt_pkg::CH_ESCAPE, 1'b0, 1'b1, "<math>\\"},    // backslash while opening
    '{tmdt_pkg::CH_DOLLAR, 1'b0, 1'b1, "$"},
    '{tmdt_pkg::CH_DOLLAR, 1'b1, 1'b1, ""},            // stream ends after delimiter
    '{"b",                 1'b0, 1'b1, "b"},           // ... so no close tag ever
    '{tmdt_pkg::CH_ESCAPE, 1'b1, 1'b1, "\\"},          // stream ends on a backslash
    '{tmdt_pkg::CH_DOLLAR, 1'b0, 1'b1, ""},            // escape was dropped: delimiter
    '{"c",                 1'b0, 1'b1, "<math>c"},
    '{tmdt_pkg::CH_DOLLAR, 1'b0, 1'b1, ""},
    '{"d",                 1'b1, 1'b1, "</math>d"}     // full eight-byte run
  };

  // Predictor state
  tmdt_pkg::mode_t pred_mode;
  logic            pred_esc;
  tag_char_t       step_chars [$];   // characters caused by the request just accepted
  tag_char_t       pending_chars [$];

  int  mismatches;
  int  cycles;
  int  hold_req;   // long receiver hold-off, picked up by the sink process
  bit  steady;     // stretch with no idling on either side

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic void put_char(logic [7:0] c);
    tag_char_t t;
    t.data = c;
    t.last = 1'b0;
    step_chars.push_back(t);
  endfunction

  // Runs one accepted request through the delimiter state machine, leaving the
  // characters it causes in step_chars.
  function automatic void advance_tagger(logic [7:0] b, logic eos);
    string tag;
    step_chars.delete();
    if (pred_esc) begin
      put_char(b);
      pred_esc = 1'b0;
    end else begin
      case (pred_mode)
        tmdt_pkg::MODE_TEXT, tmdt_pkg::MODE_MATH: begin
          if (b == tmdt_pkg::CH_ESCAPE) begin
            put_char(b);
            pred_esc = 1'b1;
          end else if (b == tmdt_pkg::CH_DOLLAR) begin
            pred_mode = (pred_mode == tmdt_pkg::MODE_TEXT) ? tmdt_pkg::MODE_OPENING
                                                           : tmdt_pkg::MODE_CLOSING;
          end else begin
            put_char(b);
          end
        end
        default: begin
          tag = (pred_mode == tmdt_pkg::MODE_OPENING) ? "<math>" : "</math>";
          for (int i = 0; i < tag.len(); i++) put_char(tag[i]);
          if (b == tmdt_pkg::CH_ESCAPE) begin
            put_char(b);
            pred_esc = 1'b1;
          end else if (b != tmdt_pkg::CH_DOLLAR) begin
            put_char(b);
          end
          pred_mode = (pred_mode == tmdt_pkg::MODE_OPENING) ? tmdt_pkg::MODE_MATH
                                                            : tmdt_pkg::MODE_TEXT;
        end
      endcase
    end
    if (eos) begin
      pred_mode = tmdt_pkg::MODE_TEXT;
      pred_esc  = 1'b0;
    end
    if (step_chars.size() > 0) step_chars[step_chars.size() - 1].last = 1'b1;
  endfunction

  // Offers one request, waits for acceptance, then queues what it should cause.
  // With fixed set, the typed-in text replaces the predicted characters.
  task automatic send_request(logic [7:0] b, logic eos, bit fixed, string text);
    int g;
    din.valid         <= 1'b1;
    din.in_byte       <= b;
    din.end_of_stream <= eos;
    do @(posedge clk); while (!din.ready);
    advance_tagger(b, eos);
    if (fixed) begin
      step_chars.delete();
      for (int i = 0; i < text.len(); i++) put_char(text[i]);
      if (step_chars.size() > 0) step_chars[step_chars.size() - 1].last = 1'b1;
    end
    foreach (step_chars[i]) pending_chars.push_back(step_chars[i]);
    g = pick_gap();
    if (g > 0) begin
      din.valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  // Source byte with delimiters and escapes well represented.
  function automatic logic [7:0] pick_byte();
    int r;
    r = $urandom_range(0, 99);
    if (r < 15) return tmdt_pkg::CH_DOLLAR;
    if (r < 25) return tmdt_pkg::CH_ESCAPE;
    return 8'($urandom_range(0, 255));
  endfunction

  // Receiver: one ready update per edge at most.
  initial begin : sink_proc
    int n;
    int g;
    forever begin
      if (hold_req > 0) begin
        n = hold_req;
        hold_req = 0;
        dout.ready <= 1'b0;
      end else begin
        g = pick_gap();
        dout.ready <= (g == 0);
        n = (g == 0) ? 1 : g;
      end
      repeat (n) @(posedge clk);
    end
  end

  // Compare each output character with the oldest expectation.
  always @(posedge clk) begin : check_proc
    tag_char_t want;
    if (!rst && dout.valid && dout.ready) begin
      if (pending_chars.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected output: byte %h last %b", dout.out_byte, dout.last_of_run);
      end else begin
        want = pending_chars.pop_front();
        if (want.data !== dout.out_byte || want.last !== dout.last_of_run) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected byte %h last %b, got byte %h last %b",
                     want.data, want.last, dout.out_byte, dout.last_of_run);
        end
      end
    end
  end

  initial begin : main_proc
    int sent;
    int len;
    logic eos;
    clk        = 1'b0;
    cycles     = 0;
    mismatches = 0;
    hold_req   = 0;
    steady     = 1'b0;
    pred_mode  = tmdt_pkg::MODE_TEXT;
    pred_esc   = 1'b0;
    rst               <= 1'b1;
    din.valid         <= 1'b0;
    din.in_byte       <= 8'h00;
    din.end_of_stream <= 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < N_DIR; i++)
      send_request(dir_tab[i].in_byte, dir_tab[i].eos, dir_tab[i].fixed, dir_tab[i].text);

    // Random part: streams of random length, each closed by end_of_stream unless
    // cut short by N_RANDOM, with the occasional stray end mark inside a stream.
    sent = 0;
    while (sent < N_RANDOM) begin
      len = $urandom_range(1, 30);
      for (int k = 0; k < len && sent < N_RANDOM; k++) begin
        // long receiver hold-off while requests keep coming: the queue fills
        if (sent == 40) hold_req = LONG_HOLD;
        // sender pauses until every expected character is out
        if (sent == 140) begin
          din.valid <= 1'b0;
          do @(posedge clk); while (pending_chars.size() != 0);
        end
        steady = (sent >= 200 && sent < 240);
        eos = (k == len - 1) || ($urandom_range(0, 99) < 4);
        send_request(pick_byte(), eos, 1'b0, "");
        sent++;
      end
    end

    din.valid <= 1'b0;
    while (pending_chars.size() != 0) @(posedge clk);
    repeat (END_WAIT) @(posedge clk);
    if (mismatches == 0 && pending_chars.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
